// ===== hw/rtl/apwa_pkg.sv =====
// shared types, constants and tables for the pitch window average unit
`timescale 1ns / 1ps

package apwa_pkg;

  // default configuration
  localparam int WINDOW_ATTEMPTS_DEF     = 16;
  localparam int ANGLE_FRACTION_BITS_DEF = 8;
  localparam int CORDIC_ITERATIONS_DEF   = 16;

  // fixed widths of the datapath
  localparam int AXIS_W    = 16;
  localparam int PITCH_W   = 15;
  localparam int GOOD_W    = 5;
  localparam int SUM_W     = 28;
  localparam int ROOT_W    = 32;
  localparam int MAG2_W    = 32;
  localparam int CORDIC_W  = 36;
  localparam int ANGLE_W   = 32;
  localparam int SCALED_W  = 38;
  localparam int STEP_W    = 5;
  localparam int PRESHIFT  = 16;
  localparam int SQRT_STEPS = 16;
  localparam int TABLE_LEN = 24;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 24;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam int VERTICAL_CENTIDEG = 9000;
  localparam int CENTI_SCALE = 100;

  // atan(2^-i) in degrees, 24 fractional bits
  localparam logic [ANGLE_W-1:0] ATAN_TABLE [TABLE_LEN] = '{
    32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938,
    32'd60000934,  32'd30029717,  32'd15018523,  32'd7509720,
    32'd3754917,   32'd1877466,   32'd938734,    32'd469367,
    32'd234684,    32'd117342,    32'd58671,     32'd29335,
    32'd14668,     32'd7334,      32'd3667,      32'd1833,
    32'd917,       32'd458,       32'd229,       32'd115
  };

  // one queued read attempt
  typedef struct packed {
    logic signed [AXIS_W-1:0] ax;
    logic signed [AXIS_W-1:0] ay;
    logic signed [AXIS_W-1:0] az;
    logic                     read_ok;
    logic                     last;
  } apwa_item_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } apwa_qstat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_Y,
    ST_SQ_Z,
    ST_SQRT,
    ST_CINIT,
    ST_CORDIC,
    ST_SCALE,
    ST_ROUND,
    ST_ACC,
    ST_FIN,
    ST_DIV,
    ST_OUT
  } apwa_state_t;

endpackage

// ===== hw/rtl/apwa_front.sv =====
// front end: accepts read attempts and marks the last one of each window
`timescale 1ns / 1ps

module apwa_front #(
  parameter int WINDOW_ATTEMPTS = apwa_pkg::WINDOW_ATTEMPTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [apwa_pkg::IN_DATA_W-1:0]    s_tdata,
  input  logic                              s_tuser,
  input  apwa_pkg::apwa_qstat_t             qstat,
  output logic                              push,
  output apwa_pkg::apwa_item_t              push_item
);
  import apwa_pkg::*;

  localparam int ATT_W = (WINDOW_ATTEMPTS > 1) ? $clog2(WINDOW_ATTEMPTS) : 1;
  localparam logic [ATT_W-1:0] ATT_LAST = ATT_W'(WINDOW_ATTEMPTS - 1);

  logic [ATT_W-1:0] attempt_count;
  logic             is_last;

  // take a beat whenever the queue has room
  assign s_tready = !qstat.full;
  assign push     = s_tvalid && s_tready;
  assign is_last  = (attempt_count == ATT_LAST);

  always_comb begin
    push_item.ax      = s_tdata[AXIS_W-1:0];
    push_item.ay      = s_tdata[2*AXIS_W-1:AXIS_W];
    push_item.az      = s_tdata[3*AXIS_W-1:2*AXIS_W];
    push_item.read_ok = s_tuser;
    push_item.last    = is_last;
  end

  // attempt counter within the window
  always_ff @(posedge clk) begin
    if (rst) begin
      attempt_count <= '0;
    end else if (push) begin
      attempt_count <= is_last ? '0 : attempt_count + 1'b1;
    end
  end

endmodule

// ===== hw/rtl/apwa_queue.sv =====
// short queue between front end and compute back end
`timescale 1ns / 1ps

module apwa_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  apwa_pkg::apwa_item_t  push_item,
  input  logic                  pop,
  output apwa_pkg::apwa_item_t  pop_item,
  output apwa_pkg::apwa_qstat_t qstat
);
  import apwa_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  apwa_item_t       mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   fill;

  assign qstat.full  = (fill == (PTR_W+1)'(QUEUE_DEPTH));
  assign qstat.empty = (fill == '0);
  assign pop_item    = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

endmodule

// ===== hw/rtl/apwa_back.sv =====
// back end: square root, cordic, accumulation, window division, result register
`timescale 1ns / 1ps

module apwa_back #(
  parameter int WINDOW_ATTEMPTS     = apwa_pkg::WINDOW_ATTEMPTS_DEF,
  parameter int ANGLE_FRACTION_BITS = apwa_pkg::ANGLE_FRACTION_BITS_DEF,
  parameter int CORDIC_ITERATIONS   = apwa_pkg::CORDIC_ITERATIONS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  apwa_pkg::apwa_qstat_t           qstat,
  input  apwa_pkg::apwa_item_t            pop_item,
  output logic                            pop,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [apwa_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                            m_tuser
);
  import apwa_pkg::*;

  localparam int CNT_W = $clog2(WINDOW_ATTEMPTS + 1);
  localparam int SH    = 24 - ANGLE_FRACTION_BITS;
  localparam logic [SCALED_W-1:0] HALF = SCALED_W'(1) << (SH - 1);
  localparam logic [STEP_W-1:0] CORDIC_LAST = STEP_W'(CORDIC_ITERATIONS - 1);
  localparam logic [STEP_W-1:0] SQRT_LAST   = STEP_W'(SQRT_STEPS - 1);
  localparam logic [STEP_W-1:0] DIV_LAST    = STEP_W'(SUM_W - 1);
  localparam logic [SUM_W-1:0] VERT_VAL =
    SUM_W'(VERTICAL_CENTIDEG) << ANGLE_FRACTION_BITS;

  apwa_state_t state, state_next;

  logic [STEP_W-1:0]          step, step_next;
  apwa_item_t                 cur, cur_next;
  logic [MAG2_W-1:0]          rem_v, rem_v_next;
  logic [MAG2_W-1:0]          bit_v, bit_v_next;
  logic [ROOT_W-1:0]          root, root_next;
  logic signed [CORDIC_W-1:0] x, x_next, y, y_next;
  logic signed [ANGLE_W-1:0]  z, z_next;
  logic [SCALED_W-1:0]        scaled, scaled_next;
  logic signed [SUM_W-1:0]    sample, sample_next;
  logic signed [SUM_W-1:0]    sum, sum_next;
  logic [CNT_W-1:0]           good, good_next;
  logic [SUM_W-1:0]           dq, dq_next;
  logic [CNT_W-1:0]           drem, drem_next;
  logic                       out_valid, out_valid_next;
  logic [PITCH_W-1:0]         out_pitch, out_pitch_next;
  logic                       out_status, out_status_next;
  logic [GOOD_W-1:0]          out_good, out_good_next;

  // combinational helpers
  logic signed [2*AXIS_W-1:0] sq;
  logic [MAG2_W:0]            trial_sum;
  logic signed [CORDIC_W-1:0] dx, dy;
  logic [ANGLE_W-1:0]         zabs;
  logic [SCALED_W-1:0]        rounded;
  logic signed [SUM_W:0]      acc_wide;
  logic [CNT_W:0]             dtrial;
  logic [SUM_W-1:0]           pmag;
  logic [AXIS_W-1:0]          ax_abs;

  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tdata  = {{(OUT_DATA_W-PITCH_W-GOOD_W){1'b0}}, out_good, out_pitch};

  // registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      sum       <= '0;
      good      <= '0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      sum       <= sum_next;
      good      <= good_next;
    end
  end

  always_ff @(posedge clk) begin
    step       <= step_next;
    cur        <= cur_next;
    rem_v      <= rem_v_next;
    bit_v      <= bit_v_next;
    root       <= root_next;
    x          <= x_next;
    y          <= y_next;
    z          <= z_next;
    scaled     <= scaled_next;
    sample     <= sample_next;
    dq         <= dq_next;
    drem       <= drem_next;
    out_pitch  <= out_pitch_next;
    out_status <= out_status_next;
    out_good   <= out_good_next;
  end

  // sequencer and datapath
  always_comb begin
    state_next      = state;
    step_next       = step;
    cur_next        = cur;
    rem_v_next      = rem_v;
    bit_v_next      = bit_v;
    root_next       = root;
    x_next          = x;
    y_next          = y;
    z_next          = z;
    scaled_next     = scaled;
    sample_next     = sample;
    sum_next        = sum;
    good_next       = good;
    dq_next         = dq;
    drem_next       = drem;
    out_valid_next  = out_valid && !m_tready;
    out_pitch_next  = out_pitch;
    out_status_next = out_status;
    out_good_next   = out_good;
    pop             = 1'b0;

    sq        = (state == ST_SQ_Y) ? cur.ay * cur.ay : cur.az * cur.az;
    trial_sum = {1'b0, MAG2_W'(root)} + {1'b0, bit_v};
    dx        = y >>> step;
    dy        = x >>> step;
    zabs      = z[ANGLE_W-1] ? ANGLE_W'(-z) : ANGLE_W'(z);
    rounded   = (scaled + HALF) >> SH;
    acc_wide  = (SUM_W+1)'(sum) + (SUM_W+1)'(sample);
    dtrial    = {drem, dq[SUM_W-1]};
    pmag      = dq >> ANGLE_FRACTION_BITS;
    ax_abs    = cur.ax[AXIS_W-1] ? AXIS_W'(-cur.ax) : AXIS_W'(cur.ax);

    case (state)
      ST_IDLE: begin
        if (!qstat.empty) begin
          pop      = 1'b1;
          cur_next = pop_item;
          if (pop_item.read_ok) state_next = ST_SQ_Y;
          else if (pop_item.last) state_next = ST_FIN;
        end
      end
      // sum of squares, one product per cycle
      ST_SQ_Y: begin
        rem_v_next = MAG2_W'(sq);
        state_next = ST_SQ_Z;
      end
      ST_SQ_Z: begin
        rem_v_next = rem_v + MAG2_W'(sq);
        root_next  = '0;
        bit_v_next = MAG2_W'(1) << 30;
        step_next  = '0;
        state_next = ST_SQRT;
      end
      // integer square root, one result bit per cycle
      ST_SQRT: begin
        if ({1'b0, rem_v} >= trial_sum) begin
          rem_v_next = rem_v - MAG2_W'(trial_sum);
          root_next  = ROOT_W'((MAG2_W'(root) >> 1) + bit_v);
        end else begin
          root_next  = root >> 1;
        end
        bit_v_next = bit_v >> 2;
        step_next  = step + 1'b1;
        if (step == SQRT_LAST) state_next = ST_CINIT;
      end
      // zero and vertical cases skip the rotation
      ST_CINIT: begin
        step_next = '0;
        if (cur.ax == '0) begin
          sample_next = '0;
          state_next  = ST_ACC;
        end else if (root == '0) begin
          sample_next = cur.ax[AXIS_W-1] ? -VERT_VAL : VERT_VAL;
          state_next  = ST_ACC;
        end else begin
          x_next     = CORDIC_W'(root) <<< PRESHIFT;
          y_next     = CORDIC_W'(ax_abs) <<< PRESHIFT;
          z_next     = '0;
          state_next = ST_CORDIC;
        end
      end
      // vectoring rotation, one step per cycle
      ST_CORDIC: begin
        if (!y[CORDIC_W-1]) begin
          x_next = x + dx;
          y_next = y - dy;
          z_next = z + ATAN_TABLE[step];
        end else begin
          x_next = x - dx;
          y_next = y + dy;
          z_next = z - ATAN_TABLE[step];
        end
        step_next = step + 1'b1;
        if (step == CORDIC_LAST) state_next = ST_SCALE;
      end
      ST_SCALE: begin
        scaled_next = SCALED_W'(zabs) * SCALED_W'(CENTI_SCALE);
        state_next  = ST_ROUND;
      end
      ST_ROUND: begin
        if (z[ANGLE_W-1] ^ cur.ax[AXIS_W-1]) sample_next = -SUM_W'(rounded);
        else sample_next = SUM_W'(rounded);
        state_next = ST_ACC;
      end
      // saturating accumulate
      ST_ACC: begin
        if (acc_wide > (SUM_W+1)'($signed(SUM_MAX))) sum_next = SUM_MAX;
        else if (acc_wide < (SUM_W+1)'($signed(SUM_MIN))) sum_next = SUM_MIN;
        else sum_next = acc_wide[SUM_W-1:0];
        good_next  = good + 1'b1;
        state_next = cur.last ? ST_FIN : ST_IDLE;
      end
      // end of window: divide magnitude of sum by the good count
      ST_FIN: begin
        dq_next    = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
        drem_next  = '0;
        step_next  = '0;
        state_next = (good == '0) ? ST_OUT : ST_DIV;
      end
      ST_DIV: begin
        if (dtrial >= {1'b0, good}) begin
          drem_next = CNT_W'(dtrial - {1'b0, good});
          dq_next   = {dq[SUM_W-2:0], 1'b1};
        end else begin
          drem_next = CNT_W'(dtrial);
          dq_next   = {dq[SUM_W-2:0], 1'b0};
        end
        step_next = step + 1'b1;
        if (step == DIV_LAST) state_next = ST_OUT;
      end
      // load result register once it is free
      ST_OUT: begin
        if (!out_valid || m_tready) begin
          out_valid_next = 1'b1;
          if (good == '0) begin
            out_pitch_next  = '0;
            out_status_next = 1'b1;
            out_good_next   = '0;
          end else begin
            out_pitch_next  = sum[SUM_W-1] ? PITCH_W'(-pmag) : PITCH_W'(pmag);
            out_status_next = 1'b0;
            out_good_next   = GOOD_W'(good);
          end
          sum_next   = '0;
          good_next  = '0;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/accel_pitch_window_average_unit.sv =====
// top level of the accelerometer pitch window average unit
`timescale 1ns / 1ps

// Each input beat is one read attempt; beats with tuser set carry a good
// sample whose pitch atan2(ax, sqrt(ay^2+az^2)) is computed in centidegrees
// with ANGLE_FRACTION_BITS fractional bits and summed. After WINDOW_ATTEMPTS
// attempts one result beat gives the truncated average, a status flag
// (1 = no good samples) and the good count. A good sample passes through the back
// end as one pop, two squaring steps, 16 root steps, one setup step, the rotation
// steps, scaling, rounding and accumulation; a good sample with ax zero or with
// ay and az both zero skips the rotation; a failed read is only popped. The
// window end adds divide setup, a 28-step divide and the result load, plus any
// wait for the result register to drain. The input queue holds two beats so
// attempts are taken while the back end works or a result waits.

module accel_pitch_window_average_unit
  import apwa_pkg::*;
#(
  parameter int WINDOW_ATTEMPTS     = WINDOW_ATTEMPTS_DEF,
  parameter int ANGLE_FRACTION_BITS = ANGLE_FRACTION_BITS_DEF,
  parameter int CORDIC_ITERATIONS   = CORDIC_ITERATIONS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // ax, ay, az
  input  logic                  s_tuser,   // read_ok
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // pitch_centideg, good_count, zero pad
  output logic                  m_tuser    // status
);

  apwa_qstat_t qstat;
  apwa_item_t  push_item, pop_item;
  logic        push, pop;

  apwa_front #(
    .WINDOW_ATTEMPTS(WINDOW_ATTEMPTS)
  ) u_front (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .qstat(qstat), .push(push), .push_item(push_item)
  );

  apwa_queue u_queue (
    .clk(clk), .rst(rst),
    .push(push), .push_item(push_item),
    .pop(pop), .pop_item(pop_item), .qstat(qstat)
  );

  apwa_back #(
    .WINDOW_ATTEMPTS(WINDOW_ATTEMPTS),
    .ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS),
    .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
  ) u_back (
    .clk(clk), .rst(rst),
    .qstat(qstat), .pop_item(pop_item), .pop(pop),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  // queue never written when full nor read when empty
  assert property (@(posedge clk) disable iff (rst) push |-> !qstat.full)
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (rst) pop |-> !qstat.empty)
    else $error("queue underflow");
  // an empty window reports zero pitch and zero count
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[PITCH_W+GOOD_W-1:0] == '0))
    else $error("failure result carries data");
  // good count never exceeds the window
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && WINDOW_ATTEMPTS < 32) |->
      (m_tdata[PITCH_W+GOOD_W-1:PITCH_W] <= GOOD_W'(WINDOW_ATTEMPTS)))
    else $error("good count above window");

endmodule

// ===== verif/tb.sv =====
// self-checking testbench for the pitch window average unit
`timescale 1ns / 1ps

// scoreboard: predicts window results from accepted read attempts
class pitch_window_sb;
  int unsigned attempts;
  int unsigned goods;
  longint sum;
  logic [apwa_pkg::PITCH_W-1:0] exp_pitch [$];
  logic exp_status [$];
  logic [apwa_pkg::GOOD_W-1:0] exp_good [$];
  int errors;

  function new();
    attempts = 0;
    goods = 0;
    sum = 0;
    errors = 0;
  endfunction

  // floor shift of a signed value
  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  // integer square root of a 32-bit value
  function automatic longint root32(longint v);
    longint r;
    r = 0;
    for (int b = 16; b >= 0; b--) begin
      if ((r + (64'sd1 << b)) * (r + (64'sd1 << b)) <= v) r = r + (64'sd1 << b);
    end
    return r;
  endfunction

  // pitch of one good sample, centidegrees with fraction bits
  function automatic longint sample_angle(int ax, int ay, int az);
    longint r, x, y, z, dx, dy, val, mag;
    int sh;
    sh = 24 - apwa_pkg::ANGLE_FRACTION_BITS_DEF;
    if (ax == 0) return 0;
    r = root32(longint'(ay) * ay + longint'(az) * az);
    if (r == 0) begin
      val = 9000 * (64'sd1 << apwa_pkg::ANGLE_FRACTION_BITS_DEF);
      return ax < 0 ? -val : val;
    end
    x = r <<< 16;
    y = (ax < 0 ? -longint'(ax) : longint'(ax)) <<< 16;
    z = 0;
    for (int i = 0; i < apwa_pkg::CORDIC_ITERATIONS_DEF && i < apwa_pkg::TABLE_LEN; i++) begin
      dx = fshift(y, i);
      dy = fshift(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += longint'(apwa_pkg::ATAN_TABLE[i]);
      end else begin
        x -= dx; y += dy; z -= longint'(apwa_pkg::ATAN_TABLE[i]);
      end
    end
    mag = (z < 0 ? -z : z) * 100;
    val = (mag + (64'sd1 << (sh - 1))) >> sh;
    if (z < 0) val = -val;
    return ax < 0 ? -val : val;
  endfunction

  // note one accepted read attempt
  function void note_attempt(logic signed [15:0] ax, logic signed [15:0] ay,
                             logic signed [15:0] az, logic ok);
    longint avg;
    if (ok) begin
      sum += sample_angle(ax, ay, az);
      if (sum > 134217727) sum = 134217727;
      if (sum < -134217728) sum = -134217728;
      goods++;
    end
    attempts++;
    if (attempts < apwa_pkg::WINDOW_ATTEMPTS_DEF) return;
    if (goods != 0) begin
      avg = sum / longint'(goods);
      avg = avg / (64'sd1 << apwa_pkg::ANGLE_FRACTION_BITS_DEF);
      exp_pitch.push_back(avg[apwa_pkg::PITCH_W-1:0]);
      exp_status.push_back(1'b0);
      exp_good.push_back(goods[apwa_pkg::GOOD_W-1:0]);
    end else begin
      exp_pitch.push_back('0);
      exp_status.push_back(1'b1);
      exp_good.push_back('0);
    end
    attempts = 0;
    goods = 0;
    sum = 0;
  endfunction

  // compare one result beat with the oldest expectation
  function void check_result(logic [apwa_pkg::OUT_DATA_W-1:0] d, logic st);
    logic [apwa_pkg::PITCH_W-1:0] p;
    logic s;
    logic [apwa_pkg::GOOD_W-1:0] g;
    if (exp_pitch.size() == 0) begin
      $error("unexpected result beat data=%h status=%b", d, st);
      errors++;
      return;
    end
    p = exp_pitch.pop_front();
    s = exp_status.pop_front();
    g = exp_good.pop_front();
    if (d[apwa_pkg::PITCH_W-1:0] !== p) begin
      $error("pitch_centideg exp %0d got %0d", $signed(p),
             $signed(d[apwa_pkg::PITCH_W-1:0]));
      errors++;
    end
    if (st !== s) begin
      $error("status exp %0b got %0b", s, st);
      errors++;
    end
    if (d[apwa_pkg::PITCH_W +: apwa_pkg::GOOD_W] !== g) begin
      $error("good_count exp %0d got %0d", g, d[apwa_pkg::PITCH_W +: apwa_pkg::GOOD_W]);
      errors++;
    end
  endfunction
endclass

module tb;
  import apwa_pkg::*;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata;
  logic s_tuser;
  logic m_tvalid;
  logic m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic m_tuser;

  pitch_window_sb sb;
  int idle_cycles;
  bit sending_done;
  bit hold_off;

  accel_pitch_window_average_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // offer one read attempt and wait until it is taken
  task automatic send_attempt(logic signed [15:0] ax, logic signed [15:0] ay,
                              logic signed [15:0] az, logic ok, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {az, ay, ax};
    s_tuser <= ok;
    do @(posedge clk); while (!s_tready);
    sb.note_attempt(ax, ay, az, ok);
  endtask

  // random axis value, biased toward extremes and small values
  function automatic logic [15:0] pick_axis();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'($signed($urandom_range(0, 20)) - 10);
      default: return 16'($urandom);
    endcase
  endfunction

  // sender
  initial begin
    logic signed [15:0] dir_ax [10] = '{0, 0, 100, -100, -32768, 32767, 32767, -32768, 1, -1};
    logic signed [15:0] dir_ay [10] = '{0, 500, 0, 0, -32768, 32767, -32768, 0, -32768, 0};
    logic signed [15:0] dir_az [10] = '{0, 500, 0, 0, -32768, 32767, -32768, 32767, 0, 1};
    bit gaps;
    sb = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    sending_done = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: one window of special cases, then an all-failed window
    for (int i = 0; i < 16; i++) begin
      if (i < 10) send_attempt(dir_ax[i], dir_ay[i], dir_az[i], 1'b1, 1'b0);
      else send_attempt(16'($urandom), 16'($urandom), 16'($urandom), 1'b0, 1'b0);
    end
    for (int i = 0; i < 16; i++)
      send_attempt(16'($urandom), 16'($urandom), 16'($urandom), 1'b0, 1'b0);
    // random windows, some bursts without gaps
    for (int i = 0; i < 544; i++) begin
      if (i % 64 == 0) gaps = $urandom_range(0, 3) != 0;
      send_attempt(pick_axis(), pick_axis(), pick_axis(), $urandom_range(0, 4) != 0, gaps);
    end
    s_tvalid <= 1'b0;
    sending_done = 1'b1;
  end

  // receiver with random stalls and one long hold-off
  initial begin
    int gap;
    m_tready = 1'b0;
    hold_off = 1'b0;
    @(negedge rst);
    forever begin
      // hold off early on so the queue fills and stalls the sender
      if (!hold_off) begin
        hold_off = 1'b1;
        m_tready <= 1'b0;
        repeat (1000) @(posedge clk);
      end
      gap = $urandom_range(0, 10);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      sb.check_result(m_tdata, m_tuser);
    end
  end

  // watchdog and end of run
  initial begin
    idle_cycles = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles > 5000) begin
        $display("TB_ERROR");
        $finish;
      end
      if (sending_done && sb.exp_pitch.size() == 0) begin
        repeat (200) @(posedge clk);
        if (sb.errors == 0 && sb.exp_pitch.size() == 0 && !m_tvalid) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
      end
    end
  end
endmodule
